FILE: sv/ladrc_pkg.sv
// Shared types, constants and the micro-step table of the linear ADRC controller.
// Used by the channel interfaces, the arithmetic unit, the divider and the top level.
`default_nettype none

package ladrc_pkg;

	localparam int DATA_W    = 32;
	localparam int BW_W      = 31;
	localparam int CFG_IDX_W = 3;
	localparam int SUM_W     = 34;
	localparam int WIDE_W    = 48;
	localparam int FRAC_Q    = 16;
	localparam int FRAC_DT   = 24;
	localparam int NUM_STEPS = 20;
	localparam int STEP_W    = 5;
	localparam int DIV_BITS  = 48;
	localparam int DIV_CNT_W = 6;

	typedef logic signed [DATA_W-1:0] q_t;

	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBS_BW     = 3'd0,
		CFG_CTL_BW     = 3'd1,
		CFG_MODEL_GAIN = 3'd2,
		CFG_DRIVE_LO   = 3'd3,
		CFG_DRIVE_HI   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WB,
		S_DIV,
		S_CLAMP,
		S_FINISH
	} ladrc_state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_MUL16,
		OP_MUL24
	} alu_op_t;

	typedef enum logic [4:0] {
		SEL_ZERO,
		SEL_WO,
		SEL_WC,
		SEL_B0,
		SEL_PREV,
		SEL_MEAS,
		SEL_TGT,
		SEL_DT,
		SEL_Z1,
		SEL_Z2,
		SEL_Z3,
		SEL_W2,
		SEL_K1,
		SEL_K2,
		SEL_K3,
		SEL_E,
		SEL_T1,
		SEL_T2
	} opnd_t;

	typedef struct packed {
		alu_op_t op;
		opnd_t   a;
		opnd_t   b;
		opnd_t   c;
		logic    neg_b;
		logic    neg_c;
		opnd_t   dst;
	} uop_t;

	typedef struct packed {
		logic    exec;
		alu_op_t op;
		logic    neg_b;
		logic    neg_c;
	} alu_ctrl_t;

	// One observer and control update as a sequence of shared-unit operations.
	// Scratch registers are reused once their old contents are dead.
	function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = '{OP_MUL16, SEL_WO,  SEL_WO,   SEL_ZERO, 1'b0, 1'b0, SEL_W2};
			5'd1:  u = '{OP_ADD,   SEL_WO,  SEL_WO,   SEL_WO,   1'b0, 1'b0, SEL_K1};
			5'd2:  u = '{OP_ADD,   SEL_W2,  SEL_W2,   SEL_W2,   1'b0, 1'b0, SEL_K2};
			5'd3:  u = '{OP_MUL16, SEL_W2,  SEL_WO,   SEL_ZERO, 1'b0, 1'b0, SEL_K3};
			5'd4:  u = '{OP_ADD,   SEL_Z1,  SEL_MEAS, SEL_ZERO, 1'b1, 1'b0, SEL_E};
			5'd5:  u = '{OP_MUL16, SEL_K1,  SEL_E,    SEL_ZERO, 1'b0, 1'b0, SEL_T1};
			5'd6:  u = '{OP_MUL16, SEL_B0,  SEL_PREV, SEL_ZERO, 1'b0, 1'b0, SEL_T2};
			5'd7:  u = '{OP_ADD,   SEL_Z2,  SEL_T1,   SEL_T2,   1'b1, 1'b0, SEL_T1};
			5'd8:  u = '{OP_MUL16, SEL_K2,  SEL_E,    SEL_ZERO, 1'b0, 1'b0, SEL_T2};
			5'd9:  u = '{OP_ADD,   SEL_Z3,  SEL_T2,   SEL_ZERO, 1'b1, 1'b0, SEL_T2};
			5'd10: u = '{OP_MUL16, SEL_K3,  SEL_E,    SEL_ZERO, 1'b0, 1'b0, SEL_W2};
			5'd11: u = '{OP_MUL24, SEL_DT,  SEL_W2,   SEL_ZERO, 1'b0, 1'b0, SEL_W2};
			5'd12: u = '{OP_MUL24, SEL_DT,  SEL_T1,   SEL_ZERO, 1'b0, 1'b0, SEL_T1};
			5'd13: u = '{OP_ADD,   SEL_Z1,  SEL_T1,   SEL_ZERO, 1'b0, 1'b0, SEL_Z1};
			5'd14: u = '{OP_MUL24, SEL_DT,  SEL_T2,   SEL_ZERO, 1'b0, 1'b0, SEL_T2};
			5'd15: u = '{OP_ADD,   SEL_Z2,  SEL_T2,   SEL_ZERO, 1'b0, 1'b0, SEL_Z2};
			5'd16: u = '{OP_ADD,   SEL_Z3,  SEL_W2,   SEL_ZERO, 1'b1, 1'b0, SEL_Z3};
			5'd17: u = '{OP_ADD,   SEL_TGT, SEL_Z1,   SEL_ZERO, 1'b1, 1'b0, SEL_T1};
			5'd18: u = '{OP_MUL16, SEL_WC,  SEL_T1,   SEL_ZERO, 1'b0, 1'b0, SEL_T1};
			5'd19: u = '{OP_ADD,   SEL_T1,  SEL_Z3,   SEL_ZERO, 1'b1, 1'b0, SEL_T1};
			default: u = '{OP_ADD, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0, SEL_ZERO};
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: sv/ladrc_in_if.sv
// Input channel of the linear ADRC controller: measurement, setpoint and time step.
// Depends on ladrc_pkg for the fixed-point type.
`default_nettype none

interface ladrc_in_if;
	import ladrc_pkg::*;

	logic valid;
	logic ready;
	q_t   measured_value;
	q_t   setpoint;
	q_t   time_step;

	modport source (output valid, output measured_value, output setpoint,
		output time_step, input ready);
	modport sink (input valid, input measured_value, input setpoint,
		input time_step, output ready);
endinterface

`default_nettype wire

FILE: sv/ladrc_out_if.sv
// Result channel of the linear ADRC controller: clamped drive and held flag.
// Depends on ladrc_pkg for the fixed-point type.
`default_nettype none

interface ladrc_out_if;
	import ladrc_pkg::*;

	logic valid;
	logic ready;
	q_t   drive;
	logic held;

	modport source (output valid, output drive, output held, input ready);
	modport sink (input valid, input drive, input held, output ready);
endinterface

`default_nettype wire

FILE: sv/ladrc_alu.sv
// Shared arithmetic unit: saturating three-term add and Q16.16 / Q8.24 multiply.
// The operation is registered with the raw product and sum; the result is saturated after.
`default_nettype none

module ladrc_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ladrc_pkg::alu_ctrl_t ctrl,
	input  ladrc_pkg::q_t        a,
	input  ladrc_pkg::q_t        b,
	input  ladrc_pkg::q_t        c,
	output ladrc_pkg::q_t        result
);
	import ladrc_pkg::*;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_LO = 48'shFFFF_8000_0000;

	function automatic q_t sat_wide(input logic signed [WIDE_W-1:0] x);
		q_t r;
		if (x > SAT_HI) begin
			r = Q_MAX;
		end else if (x < SAT_LO) begin
			r = Q_MIN;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

	alu_op_t                     op_q;
	logic signed [2*DATA_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [2*DATA_W-1:0]  prod_d;
	logic signed [SUM_W-1:0]     a_ext, b_ext, c_ext, b_term, c_term;
	logic signed [2*DATA_W-1:0]  shr_q16, shr_dt;

	assign prod_d = a * b;
	assign a_ext  = {{(SUM_W-DATA_W){a[DATA_W-1]}}, a};
	assign b_ext  = {{(SUM_W-DATA_W){b[DATA_W-1]}}, b};
	assign c_ext  = {{(SUM_W-DATA_W){c[DATA_W-1]}}, c};
	assign b_term = ctrl.neg_b ? -b_ext : b_ext;
	assign c_term = ctrl.neg_c ? -c_ext : c_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
		end else if (ctrl.exec) begin
			op_q <= ctrl.op;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			prod_q <= prod_d;
			sum_q  <= a_ext + b_term + c_term;
		end
	end

	// An arithmetic right shift rounds toward minus infinity.
	assign shr_q16 = prod_q >>> FRAC_Q;
	assign shr_dt  = prod_q >>> FRAC_DT;

	always_comb begin
		case (op_q)
			OP_MUL16: result = sat_wide(shr_q16[WIDE_W-1:0]);
			OP_MUL24: result = sat_wide(shr_dt[WIDE_W-1:0]);
			OP_ADD:   result = sat_wide({{(WIDE_W-SUM_W){sum_q[SUM_W-1]}}, sum_q});
			default:  result = sat_wide({{(WIDE_W-SUM_W){sum_q[SUM_W-1]}}, sum_q});
		endcase
	end
endmodule

`default_nettype wire

FILE: sv/ladrc_div.sv
// Radix-2 restoring divider for the drive: (numerator * 65536) / b0, truncated
// toward zero and saturated to Q16.16. Depends on ladrc_pkg.
`default_nettype none

module ladrc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  ladrc_pkg::q_t                  num,
	input  logic [ladrc_pkg::BW_W-1:0]     divisor,
	output logic                           done,
	output ladrc_pkg::q_t                  quot
);
	import ladrc_pkg::*;

	localparam logic [WIDE_W-1:0] MAG_POS_MAX = 48'h0000_7FFF_FFFF;
	localparam logic [WIDE_W-1:0] MAG_NEG_MAX = 48'h0000_8000_0000;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BW_W-1:0]      rem_q;
	logic [WIDE_W-1:0]    dq_q;
	logic                 neg_q;
	logic                 zero_q;

	logic [DATA_W:0]      num_ext, mag;
	logic [DATA_W-1:0]    shifted;
	logic [DATA_W:0]      diff;
	logic [DATA_W-1:0]    low_mag;

	assign num_ext = {num[DATA_W-1], num};
	assign mag     = num[DATA_W-1] ? (~num_ext + 1'b1) : num_ext;
	assign shifted = {rem_q, dq_q[WIDE_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of dq_q while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dq_q   <= {mag[DATA_W-1:0], {FRAC_Q{1'b0}}};
			neg_q  <= num[DATA_W-1];
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[BW_W-1:0];
			end else begin
				rem_q <= shifted[BW_W-1:0];
			end
			dq_q <= {dq_q[WIDE_W-2:0], ~diff[DATA_W]};
		end
	end

	assign low_mag = dq_q[DATA_W-1:0];

	always_comb begin
		if (zero_q) begin
			quot = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			quot = (dq_q > MAG_NEG_MAX) ? Q_MIN : q_t'(~low_mag + 1'b1);
		end else begin
			quot = (dq_q > MAG_POS_MAX) ? Q_MAX : q_t'(low_mag);
		end
	end

	assign done = done_q;
endmodule

`default_nettype wire

FILE: sv/linear_adrc_controller.sv
// Linear ADRC controller, third-order extended state observer, Q16.16 fixed point.
// A positive time step runs 20 operations on the shared multiply/add unit, each an execute
// and a write-back state, then the divide phase, a clamp step and the output load.
// A held step goes straight from idle to the output load, which waits while the result
// register is full and not taken. New samples are taken only when idle; the result register frees input.
// Reset (arst_n, asynchronous): observer state and previous drive clear, registers load defaults.
`default_nettype none

module linear_adrc_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ladrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ladrc_pkg::DATA_W-1:0]       cfg_data,
	ladrc_in_if.sink                           sample,
	ladrc_out_if.source                        result
);
	import ladrc_pkg::*;

	ladrc_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	uop_t uop;

	logic [BW_W-1:0] wo_q, wc_q, b0_q;
	q_t lo_q, hi_q;
	q_t z1_q, z2_q, z3_q, prev_q;
	q_t meas_q, tgt_q, dt_q;
	q_t w2_q, k1_q, k2_q, k3_q, e_q, t1_q, t2_q;
	q_t res_drive_q;
	logic res_held_q;
	logic out_valid_q;
	q_t drive_q;
	logic held_q;

	q_t opa, opb, opc, alu_result, div_quot, clamped;
	alu_ctrl_t alu_ctrl;
	logic in_ready, wb_en, last_step, div_start, div_done, load_out, dt_nonpos;

	assign uop       = uop_rom(step_q);
	assign last_step = (step_q == STEP_W'(NUM_STEPS - 1));
	assign dt_nonpos = sample.time_step[DATA_W-1] || (sample.time_step == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					state_d = dt_nonpos ? S_FINISH : S_EXEC;
				end
			end
			S_EXEC: state_d = S_WB;
			S_WB: begin
				state_d = last_step ? S_DIV : S_EXEC;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: state_d = S_FINISH;
			S_FINISH: begin
				if (!out_valid_q || result.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready       = 1'b0;
		wb_en          = 1'b0;
		div_start      = 1'b0;
		load_out       = 1'b0;
		alu_ctrl.exec  = 1'b0;
		alu_ctrl.op    = uop.op;
		alu_ctrl.neg_b = uop.neg_b;
		alu_ctrl.neg_c = uop.neg_c;
		case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_EXEC:   alu_ctrl.exec = 1'b1;
			S_WB: begin
				wb_en     = 1'b1;
				div_start = last_step;
			end
			S_FINISH: load_out = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign sample.ready = in_ready;

	always_comb begin
		case (uop.a)
			SEL_WO:   opa = q_t'({1'b0, wo_q});
			SEL_WC:   opa = q_t'({1'b0, wc_q});
			SEL_B0:   opa = q_t'({1'b0, b0_q});
			SEL_PREV: opa = prev_q;
			SEL_MEAS: opa = meas_q;
			SEL_TGT:  opa = tgt_q;
			SEL_DT:   opa = dt_q;
			SEL_Z1:   opa = z1_q;
			SEL_Z2:   opa = z2_q;
			SEL_Z3:   opa = z3_q;
			SEL_W2:   opa = w2_q;
			SEL_K1:   opa = k1_q;
			SEL_K2:   opa = k2_q;
			SEL_K3:   opa = k3_q;
			SEL_E:    opa = e_q;
			SEL_T1:   opa = t1_q;
			SEL_T2:   opa = t2_q;
			default:  opa = '0;
		endcase
	end

	always_comb begin
		case (uop.b)
			SEL_WO:   opb = q_t'({1'b0, wo_q});
			SEL_WC:   opb = q_t'({1'b0, wc_q});
			SEL_B0:   opb = q_t'({1'b0, b0_q});
			SEL_PREV: opb = prev_q;
			SEL_MEAS: opb = meas_q;
			SEL_TGT:  opb = tgt_q;
			SEL_DT:   opb = dt_q;
			SEL_Z1:   opb = z1_q;
			SEL_Z2:   opb = z2_q;
			SEL_Z3:   opb = z3_q;
			SEL_W2:   opb = w2_q;
			SEL_K1:   opb = k1_q;
			SEL_K2:   opb = k2_q;
			SEL_K3:   opb = k3_q;
			SEL_E:    opb = e_q;
			SEL_T1:   opb = t1_q;
			SEL_T2:   opb = t2_q;
			default:  opb = '0;
		endcase
	end

	// The third term is only ever zero, a scratch value or the observer bandwidth.
	always_comb begin
		case (uop.c)
			SEL_WO:  opc = q_t'({1'b0, wo_q});
			SEL_W2:  opc = w2_q;
			SEL_T2:  opc = t2_q;
			default: opc = '0;
		endcase
	end

	ladrc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.a      (opa),
		.b      (opb),
		.c      (opc),
		.result (alu_result)
	);

	// The numerator is taken straight from the unit in the last write-back cycle.
	ladrc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (alu_result),
		.divisor (b0_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	// With the low limit above the high limit, a quotient below the low limit takes the low limit and any other the high.
	always_comb begin
		if (div_quot < lo_q) begin
			clamped = lo_q;
		end else if (div_quot > hi_q) begin
			clamped = hi_q;
		end else begin
			clamped = div_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			wo_q        <= 31'd655360;
			wc_q        <= 31'd327680;
			b0_q        <= 31'd65536;
			lo_q        <= -32'sd65536;
			hi_q        <= 32'sd65536;
			z1_q        <= '0;
			z2_q        <= '0;
			z3_q        <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				step_q <= '0;
			end else if (wb_en) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_OBS_BW:     wo_q <= cfg_data[BW_W-1:0];
					CFG_CTL_BW:     wc_q <= cfg_data[BW_W-1:0];
					CFG_MODEL_GAIN: b0_q <= cfg_data[BW_W-1:0];
					CFG_DRIVE_LO:   lo_q <= q_t'(cfg_data);
					CFG_DRIVE_HI:   hi_q <= q_t'(cfg_data);
					default: ;
				endcase
			end
			if (wb_en) begin
				case (uop.dst)
					SEL_Z1:  z1_q <= alu_result;
					SEL_Z2:  z2_q <= alu_result;
					SEL_Z3:  z3_q <= alu_result;
					default: ;
				endcase
			end
			if (state_q == S_CLAMP) begin
				prev_q <= clamped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && in_ready) begin
			meas_q      <= sample.measured_value;
			tgt_q       <= sample.setpoint;
			dt_q        <= sample.time_step;
			res_drive_q <= prev_q;
			res_held_q  <= dt_nonpos;
		end
		if (wb_en) begin
			case (uop.dst)
				SEL_W2:  w2_q <= alu_result;
				SEL_K1:  k1_q <= alu_result;
				SEL_K2:  k2_q <= alu_result;
				SEL_K3:  k3_q <= alu_result;
				SEL_E:   e_q  <= alu_result;
				SEL_T1:  t1_q <= alu_result;
				SEL_T2:  t2_q <= alu_result;
				default: ;
			endcase
		end
		if (state_q == S_CLAMP) begin
			res_drive_q <= clamped;
			res_held_q  <= 1'b0;
		end
		if (load_out) begin
			drive_q <= res_drive_q;
			held_q  <= res_held_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.drive = drive_q;
	assign result.held  = held_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC || state_q == S_WB) |-> step_q < STEP_W'(NUM_STEPS))
		else $error("micro-step counter ran past the table");

	a_prev_only_on_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prev_q) |-> $past(state_q) == S_CLAMP)
		else $error("previous drive changed outside the clamp step");

	a_held_repeats_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_held_q) |-> res_drive_q == prev_q)
		else $error("held result does not repeat the previous drive");
endmodule

`default_nettype wire
